/* hw/rtl/bipc_pkg.sv */
// bipc_pkg: shared constants, codes and types of the bulk in packet coalescer
// depends on nothing; imported by the top level, the checker and the testbench
package bipc_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int FIFO_DEPTH   = 1024;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int LEN_W = $clog2(PACKET_BYTES + 1);
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int BYTE_W = 8;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(5);

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_DONE      = 2'd2,
    CMD_BUS_RESET = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // one word of an armed packet, as queued for the output side
  typedef struct packed {
    logic              ovf;
    logic              short_pkt;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
  } out_word_t;

  // per-word tags that travel alongside a ram read
  typedef struct packed {
    logic             ovf;
    logic             short_pkt;
    logic             last;
    logic [LEN_W-1:0] len;
  } word_tag_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    ptr_adv = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

/* hw/rtl/bipc_ram.sv */
// bipc_ram: simple dual-port ram, one write and one registered read port
// generic storage, no package dependency
module bipc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/bulk_in_packet_coalescer_unit.sv */
// bulk_in_packet_coalescer_unit: top level, command decode, packet arming,
// byte emission and output queue; depends on bipc_pkg and bipc_ram
//
// Bytes pushed on the input stream are stored in a 1024-byte ram fifo and cut
// into bulk in packets of 64 bytes. A tick arms a full packet when the
// endpoint is idle and enough bytes are stored; a shorter residue starts a
// hold timer and goes out as a short packet once hold_ms milliseconds (wrap
// safe) have passed. A completion frees the endpoint and re-arms with a full
// packet only. A bus reset empties the fifo and clears busy and pending; the
// overflow flag is sticky and survives it. Each armed packet leaves as one
// output word per byte, tlast on the final byte. A push, a tick or completion
// that arms nothing, and a bus reset do not hold the input. A command that arms
// a packet of n bytes holds the input until its n fifo ram reads are issued,
// one read per byte, the single read port of the ram setting one byte per
// cycle. Output stalls slow the reads through a two-word output queue; the
// queue drains while the next commands are taken. There is no clearing pass
// after reset: the read side never touches an unwritten entry.
module bulk_in_packet_coalescer_unit
  import bipc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // command stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [1:0] command, [9:2] data_byte, [41:10] now_ms, [47:42] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // packet stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] packet_byte, [14:8] packet_length, [15] overflow
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // [0] short_packet
  output logic                   m_tuser,
  output logic                   m_tlast,
  // hold time register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [HOLD_W-1:0]      cfg_data
);

  // input field split
  cmd_t              in_cmd;
  logic [BYTE_W-1:0] in_byte;
  logic [TIME_W-1:0] in_now;

  assign in_cmd  = cmd_t'(s_tdata[1:0]);
  assign in_byte = s_tdata[9:2];
  assign in_now  = s_tdata[41:10];

  // control state
  state_t            state, state_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic              busy, busy_next;
  logic              pending, pending_next;
  logic [TIME_W-1:0] since, since_next;
  logic              ovf_seen, ovf_seen_next;
  logic [HOLD_W-1:0] hold_ms;

  // current packet being read out
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [LEN_W-1:0]  pkt_len, pkt_len_next;
  logic              pkt_short, pkt_short_next;
  logic              pkt_ovf, pkt_ovf_next;

  // ram side
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              inflight;
  word_tag_t         inflight_tag;

  // output queue, two words
  out_word_t         q_mem [2];
  logic              q_rd_idx;
  logic              q_wr_idx;
  logic [1:0]        q_count;
  logic              pop;
  logic [1:0]        occ_sum;

  // arming
  logic              arm;
  logic [LEN_W-1:0]  arm_len;
  logic [TIME_W-1:0] since_eff;
  logic [TIME_W-1:0] elapsed;
  logic              full_avail;
  logic              accept;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign full_avail = (fill >= CNT_W'(PACKET_BYTES));
  assign since_eff  = pending ? since : in_now;
  assign elapsed    = in_now - since_eff;

  // a read may go out when the queue has room once this cycle's pop and the
  // word still in flight are counted
  assign pop     = m_tvalid && m_tready;
  assign occ_sum = q_count + {1'b0, inflight};

  bipc_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_ptr),
    .wr_data (in_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next     = state;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    fill_next      = fill;
    busy_next      = busy;
    pending_next   = pending;
    since_next     = since;
    ovf_seen_next  = ovf_seen;
    remaining_next = remaining;
    pkt_len_next   = pkt_len;
    pkt_short_next = pkt_short;
    pkt_ovf_next   = pkt_ovf;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;
    arm            = 1'b0;
    arm_len        = LEN_W'(PACKET_BYTES);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUSH: begin
              if (fill >= CNT_W'(FIFO_DEPTH)) begin
                ovf_seen_next = 1'b1;
              end else begin
                ram_wr_en   = 1'b1;
                wr_ptr_next = ptr_adv(wr_ptr);
                fill_next   = fill + CNT_W'(1);
              end
            end
            CMD_TICK: begin
              if (!busy) begin
                if (full_avail) begin
                  pending_next = 1'b0;
                  arm          = 1'b1;
                end else if (fill == '0) begin
                  pending_next = 1'b0;
                end else begin
                  pending_next = 1'b1;
                  since_next   = since_eff;
                  // residue has waited long enough, flush it short
                  if (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold_ms}) begin
                    pending_next = 1'b0;
                    arm          = 1'b1;
                    arm_len      = fill[LEN_W-1:0];
                  end
                end
              end
            end
            CMD_DONE: begin
              busy_next = 1'b0;
              if (full_avail) begin
                pending_next = 1'b0;
                arm          = 1'b1;
              end
            end
            CMD_BUS_RESET: begin
              rd_ptr_next  = '0;
              wr_ptr_next  = '0;
              fill_next    = '0;
              busy_next    = 1'b0;
              pending_next = 1'b0;
            end
            default: begin
            end
          endcase

          if (arm) begin
            state_next     = ST_EMIT;
            remaining_next = arm_len;
            pkt_len_next   = arm_len;
            pkt_short_next = (arm_len < LEN_W'(PACKET_BYTES));
            pkt_ovf_next   = ovf_seen;
            fill_next      = fill - CNT_W'(arm_len);
            busy_next      = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (occ_sum < 2'd2 || pop) begin
          ram_rd_en      = 1'b1;
          rd_ptr_next    = ptr_adv(rd_ptr);
          remaining_next = remaining - LEN_W'(1);
          if (remaining == LEN_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      busy      <= 1'b0;
      pending   <= 1'b0;
      since     <= '0;
      ovf_seen  <= 1'b0;
      remaining <= '0;
      inflight  <= 1'b0;
    end else begin
      state     <= state_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      fill      <= fill_next;
      busy      <= busy_next;
      pending   <= pending_next;
      since     <= since_next;
      ovf_seen  <= ovf_seen_next;
      remaining <= remaining_next;
      inflight  <= ram_rd_en;
    end
  end

  // packet tags, and the tag of the word whose ram read is under way
  always_ff @(posedge clk) begin
    pkt_len   <= pkt_len_next;
    pkt_short <= pkt_short_next;
    pkt_ovf   <= pkt_ovf_next;
    if (ram_rd_en) begin
      inflight_tag.ovf       <= pkt_ovf;
      inflight_tag.short_pkt <= pkt_short;
      inflight_tag.last      <= (remaining == LEN_W'(1));
      inflight_tag.len       <= pkt_len;
    end
  end

  // hold time register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_ms <= cfg_data;
    end
  end

  // output queue: ram data is written here in the cycle after its read
  always_ff @(posedge clk) begin
    if (inflight) begin
      q_mem[q_wr_idx] <= '{ovf:       inflight_tag.ovf,
                           short_pkt: inflight_tag.short_pkt,
                           last:      inflight_tag.last,
                           len:       inflight_tag.len,
                           data:      ram_rd_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd_idx <= 1'b0;
      q_wr_idx <= 1'b0;
      q_count  <= '0;
    end else begin
      if (inflight) begin
        q_wr_idx <= ~q_wr_idx;
      end
      if (pop) begin
        q_rd_idx <= ~q_rd_idx;
      end
      q_count <= q_count + {1'b0, inflight} - {1'b0, pop};
    end
  end

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {q_mem[q_rd_idx].ovf, q_mem[q_rd_idx].len, q_mem[q_rd_idx].data};
  assign m_tuser  = q_mem[q_rd_idx].short_pkt;
  assign m_tlast  = q_mem[q_rd_idx].last;

`ifndef ASSERT_OFF
  // read issue must never overrun the two-word queue
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (q_count + {1'b0, inflight}) <= 2'd2)
    else $error("output queue overrun");

  // stored byte count stays within the fifo
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(FIFO_DEPTH))
    else $error("fill count beyond fifo depth");

  // emission always has bytes left to read
  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (remaining != '0))
    else $error("emit state with nothing left");

  // arming a packet marks the endpoint busy
  a_arm_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && state_next == ST_EMIT) |=> busy)
    else $error("packet armed without busy mark");
`endif

endmodule

/* dv/bipc_checker.sv */
`timescale 1ns / 1ps
// bipc_checker: watches the command, packet and hold time channels of the
// coalescer, predicts every packet word and compares it with what comes out
// depends on bipc_pkg for widths, command codes and the packet word type
module bipc_checker
  import bipc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tuser,
  input  logic                   m_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [HOLD_W-1:0]      cfg_data,
  output int                     fail_count,
  output int                     words_left
);

  // shadow of the endpoint fifo and its bookkeeping
  logic [BYTE_W-1:0] byte_store [FIFO_DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       fill;
  logic              ep_busy;
  logic              residue_pending;
  logic [TIME_W-1:0] residue_since;
  logic              ovf_sticky;
  logic [HOLD_W-1:0] hold_ms;

  out_word_t expected_words[$];
  int        errors = 0;

  // pops len bytes into the expected packet words and marks the endpoint busy
  task automatic arm_packet(input int unsigned len);
    out_word_t w;
    if (len > fill) len = fill;
    for (int unsigned k = 0; k < len; k++) begin
      w.data      = byte_store[rd_ptr];
      w.len       = LEN_W'(len);
      w.short_pkt = (len < PACKET_BYTES);
      w.last      = (k + 1 == len);
      w.ovf       = ovf_sticky;
      expected_words.push_back(w);
      rd_ptr = (rd_ptr == FIFO_DEPTH - 1) ? 0 : rd_ptr + 1;
    end
    fill    = fill - len;
    ep_busy = 1'b1;
  endtask

  task automatic apply_command(input logic [IN_TDATA_W-1:0] word);
    cmd_t              cmd;
    logic [BYTE_W-1:0] data;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] waited;
    cmd  = cmd_t'(word[1:0]);
    data = word[9:2];
    now  = word[41:10];
    case (cmd)
      CMD_PUSH: begin
        if (fill >= FIFO_DEPTH) begin
          ovf_sticky = 1'b1;
        end else begin
          byte_store[wr_ptr] = data;
          wr_ptr = (wr_ptr == FIFO_DEPTH - 1) ? 0 : wr_ptr + 1;
          fill++;
        end
      end
      CMD_TICK: begin
        if (!ep_busy) begin
          if (fill >= PACKET_BYTES) begin
            residue_pending = 1'b0;
            arm_packet(PACKET_BYTES);
          end else if (fill == 0) begin
            residue_pending = 1'b0;
          end else begin
            if (!residue_pending) begin
              residue_pending = 1'b1;
              residue_since   = now;
            end
            // elapsed time modulo 2^32
            waited = now - residue_since;
            if (waited >= TIME_W'(hold_ms)) begin
              residue_pending = 1'b0;
              arm_packet(fill);
            end
          end
        end
      end
      CMD_DONE: begin
        ep_busy = 1'b0;
        if (fill >= PACKET_BYTES) begin
          residue_pending = 1'b0;
          arm_packet(PACKET_BYTES);
        end
      end
      default: begin
        // bus reset keeps the overflow flag and the residue timestamp
        rd_ptr          = 0;
        wr_ptr          = 0;
        fill            = 0;
        ep_busy         = 1'b0;
        residue_pending = 1'b0;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_word();
    out_word_t w;
    if (expected_words.size() == 0) begin
      $error("packet word with nothing expected: tdata %h tuser %b tlast %b",
             m_tdata, m_tuser, m_tlast);
      errors++;
    end else begin
      w = expected_words.pop_front();
      compare_field("packet_byte", 16'(w.data), 16'(m_tdata[7:0]));
      compare_field("packet_length", 16'(w.len), 16'(m_tdata[14:8]));
      compare_field("overflow", 16'(w.ovf), 16'(m_tdata[15]));
      compare_field("short_packet", 16'(w.short_pkt), 16'(m_tuser));
      compare_field("last", 16'(w.last), 16'(m_tlast));
    end
  endtask

  // commands are applied before the packet side so a word armed and sent on
  // the same edge would still find its expectation
  always @(posedge clk) begin
    if (rst) begin
      rd_ptr          = 0;
      wr_ptr          = 0;
      fill            = 0;
      ep_busy         = 1'b0;
      residue_pending = 1'b0;
      residue_since   = '0;
      ovf_sticky      = 1'b0;
      hold_ms         = HOLD_RESET;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) hold_ms = cfg_data;
      if (s_tvalid && s_tready) apply_command(s_tdata);
      if (m_tvalid && m_tready) check_word();
    end
    fail_count <= errors;
    words_left <= expected_words.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for bulk_in_packet_coalescer_unit
// depends on bipc_pkg, the block's rtl and bipc_checker
module tb_top;
  import bipc_pkg::*;

  // run limit, far above the slowest legal run
  localparam int LIMIT_CYCLES    = 1500000;
  // quiet cycles after the last packet word before a hold time write or the end
  localparam int DRAIN_CYCLES    = 100;
  // long receiver hold-off so the output queue fills and the input stalls
  localparam int HOLD_OFF_CYCLES = 400;
  // command words per random phase
  localparam int PHASE_ITEMS     = 44;
  // pushes in the pressure phase: two full packets and a short residue
  localparam int PRESSURE_PUSHES = 2 * PACKET_BYTES + 5;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [HOLD_W-1:0]      cfg_data;

  int                fail_count;
  int                words_left;
  logic              hold_off_req;
  int                burst_left;
  logic [TIME_W-1:0] now_ms;
  int                cycle_cnt;

  bulk_in_packet_coalescer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bipc_checker packet_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .words_left (words_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL bulk_in_packet_coalescer_unit");
    $finish;
  end

  // packet receiver: stall pattern switches between random modes, from always
  // ready down to rarely ready; a hold-off request keeps tready low for a long
  // counted stretch
  initial begin
    int mode;
    int mode_left;
    m_tready  = 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 9) < 7);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (mode_left % 3 == 0);
      endcase
    end
  end

  // offers one command word and returns at the falling edge after it is
  // taken; valid stays high inside a burst and drops only for a real gap
  task automatic send_cmd(input cmd_t cmd, input logic [BYTE_W-1:0] data,
                          input logic [TIME_W-1:0] now);
    int gap;
    s_tdata  <= {6'd0, now, data, cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
  endtask

  // stop offering and wait until every predicted packet word has come out
  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (words_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // time mostly creeps forward, with an occasional jump that can pass any hold time
  task automatic advance_time();
    if ($urandom_range(0, 19) == 0) now_ms = now_ms + $urandom_range(0, 70000);
    else now_ms = now_ms + $urandom_range(0, 3);
  endtask

  // random traffic shaped like real use: a run of pushes, a few ticks with
  // time moving on, usually an in completion, and now and then a bus reset
  // or a stray tick or completion
  task automatic run_traffic(input int n_items);
    int sent;
    int burst;
    int n_ticks;
    sent   = 0;
    now_ms = $urandom();
    while (sent < n_items) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 140) : $urandom_range(1, 20);
      repeat (burst) begin
        // now_ms is ignored on a push, so random bits there cost nothing
        send_cmd(CMD_PUSH, BYTE_W'($urandom()), TIME_W'($urandom()));
        sent++;
      end
      n_ticks = $urandom_range(1, 4);
      repeat (n_ticks) begin
        advance_time();
        send_cmd(CMD_TICK, BYTE_W'($urandom()), now_ms);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        send_cmd(CMD_DONE, BYTE_W'($urandom()), TIME_W'($urandom()));
        sent++;
      end
      case ($urandom_range(0, 11))
        0: begin
          send_cmd(CMD_BUS_RESET, BYTE_W'($urandom()), TIME_W'($urandom()));
          sent++;
        end
        1: begin
          send_cmd(CMD_DONE, BYTE_W'($urandom()), now_ms);
          sent++;
        end
        2: begin
          send_cmd(CMD_TICK, BYTE_W'($urandom()), now_ms);
          sent++;
        end
        default: ;
      endcase
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    now_ms       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, hold time at its reset value of 5 ms
    // tick on an empty fifo does nothing
    send_cmd(CMD_TICK, 8'h00, 32'h0000_0000);
    send_cmd(CMD_PUSH, 8'h00, 32'h0000_0000);
    send_cmd(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH, 8'h5A, 32'h0000_0000);
    // residue timer starts just below the wrap point
    send_cmd(CMD_TICK, 8'h00, 32'hFFFF_FFFE);
    // five ms later across the wrap: short packet of three
    send_cmd(CMD_TICK, 8'hFF, 32'h0000_0003);
    // tick while the endpoint is busy is ignored
    send_cmd(CMD_TICK, 8'h00, 32'h0000_0003);
    send_cmd(CMD_PUSH, 8'h81, 32'h0000_0000);
    // completion with only a residue leaves the endpoint idle
    send_cmd(CMD_DONE, 8'h00, 32'h0000_0000);
    // completion while not busy
    send_cmd(CMD_DONE, 8'h00, 32'h0000_0000);
    send_cmd(CMD_BUS_RESET, 8'hFF, 32'hFFFF_FFFF);
    wait_idle();
    // zero hold time flushes a residue on the tick that first sees it
    write_hold(16'd0);
    send_cmd(CMD_PUSH, 8'hC3, 32'h0000_0000);
    send_cmd(CMD_TICK, 8'h00, 32'h8000_0000);
    send_cmd(CMD_DONE, 8'h00, 32'h0000_0000);

    // random phases across hold settings, the largest first
    wait_idle();
    write_hold(16'hFFFF);
    run_traffic(PHASE_ITEMS);
    wait_idle();
    write_hold(16'd3);
    run_traffic(PHASE_ITEMS);
    wait_idle();
    write_hold(HOLD_W'($urandom_range(1, 40)));
    run_traffic(PHASE_ITEMS);
    wait_idle();
    write_hold(16'd0);
    run_traffic(PHASE_ITEMS);
    wait_idle();
    write_hold(16'd20);
    run_traffic(PHASE_ITEMS);

    // pressure: stock two full packets and a residue, then arm them while
    // the receiver holds off, so the output queue fills and arming stalls
    // the command stream
    wait_idle();
    write_hold(16'd1);
    send_cmd(CMD_BUS_RESET, 8'h00, 32'h0000_0000);
    repeat (PRESSURE_PUSHES) send_cmd(CMD_PUSH, BYTE_W'($urandom()), TIME_W'($urandom()));
    hold_off_req = 1'b1;
    now_ms = $urandom();
    send_cmd(CMD_TICK, 8'h00, now_ms);
    send_cmd(CMD_DONE, BYTE_W'($urandom()), now_ms);
    // only the residue is left, so this completion leaves the endpoint idle
    send_cmd(CMD_DONE, BYTE_W'($urandom()), now_ms);
    // residue goes out short once the hold time has passed
    send_cmd(CMD_TICK, 8'h00, now_ms);
    now_ms = now_ms + 2;
    send_cmd(CMD_TICK, 8'h00, now_ms);
    send_cmd(CMD_DONE, 8'h00, now_ms);
    send_cmd(CMD_BUS_RESET, 8'h00, now_ms);
    run_traffic(PHASE_ITEMS / 2);

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS bulk_in_packet_coalescer_unit");
    end else begin
      $display("FAIL bulk_in_packet_coalescer_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bipc_pkg.sv
hw/rtl/bipc_ram.sv
hw/rtl/bulk_in_packet_coalescer_unit.sv
dv/bipc_checker.sv
dv/tb_top.sv
